>>> hw/rtl/bgd_pkg.sv
// Shared types, constants and helper functions for the button gesture detector.
package bgd_pkg;

    // Number of tracked buttons (legal range 1 to 8).
    localparam int NUM_BUTTONS = 4;
    localparam int BTN_IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // Fixed field widths.
    localparam int LEVEL_W    = 4;
    localparam int TIME_W     = 32;
    localparam int THR_W      = 16;
    localparam int OUT_IDX_W  = 2;
    localparam int CODE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Threshold values after reset.
    localparam logic [THR_W-1:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [THR_W-1:0] DOUBLE_CLICK_RST = 16'd300;

    // At most this many events leave for one input item.
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    // Event queue between the front and back ends.
    localparam int EVQ_DEPTH  = 4;
    localparam int EVQ_PTR_W  = $clog2(EVQ_DEPTH);
    localparam int EVQ_CNT_W  = $clog2(EVQ_DEPTH + 1);

    // Input item kinds.
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TIMER  = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_PRESS   = 2'd0,
        CFG_DOUBLE_CLICK = 2'd1,
        CFG_INVERT       = 2'd2
    } t_cfg_idx;

    // Event codes as seen on the output channel.
    typedef enum logic [CODE_W-1:0] {
        EV_PRESS   = 3'd0,
        EV_RELEASE = 3'd1,
        EV_CLICK   = 3'd2,
        EV_DOUBLE  = 3'd3,
        EV_LONG    = 3'd4
    } t_event_code;

    // Per-button gesture state, one-hot.
    typedef enum logic [3:0] {
        G_IDLE     = 4'b0001,
        G_PRESSED  = 4'b0010,
        G_RELEASED = 4'b0100,
        G_LONG     = 4'b1000
    } t_gesture;

    // Event bits of one button, in emission order (lowest bit leaves first).
    localparam int EVB_NUM = 5;
    localparam int EVB_W   = $clog2(EVB_NUM);
    localparam logic [EVB_W-1:0] EVB_DOUBLE  = 3'd0;
    localparam logic [EVB_W-1:0] EVB_RELEASE = 3'd1;
    localparam logic [EVB_W-1:0] EVB_PRESS   = 3'd2;
    localparam logic [EVB_W-1:0] EVB_CLICK   = 3'd3;
    localparam logic [EVB_W-1:0] EVB_LONG    = 3'd4;

    typedef logic [EVB_NUM-1:0] t_btn_ev;
    typedef t_btn_ev [NUM_BUTTONS-1:0] t_ev_mask;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } t_evq_stat;

    // Map an event bit position to its output code.
    function automatic t_event_code ev_code(input logic [EVB_W-1:0] bpos);
        t_event_code code;
        case (bpos)
            EVB_DOUBLE:  code = EV_DOUBLE;
            EVB_RELEASE: code = EV_RELEASE;
            EVB_PRESS:   code = EV_PRESS;
            EVB_CLICK:   code = EV_CLICK;
            EVB_LONG:    code = EV_LONG;
            default:     code = EV_PRESS;
        endcase
        return code;
    endfunction

    // Low two bits of a button index for the output field.
    function automatic logic [OUT_IDX_W-1:0] out_idx(input logic [BTN_IDX_W-1:0] idx);
        logic [BTN_IDX_W+OUT_IDX_W-1:0] wide;
        wide = {{OUT_IDX_W{1'b0}}, idx};
        return wide[OUT_IDX_W-1:0];
    endfunction

endpackage

>>> hw/rtl/bgd_if.sv
// Valid/ready channel interfaces for input items and output events.
interface bgd_in_if;
    import bgd_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [LEVEL_W-1:0] button_levels;
    logic [TIME_W-1:0]  now_ms;

    modport source (output valid, output mode, output button_levels, output now_ms,
                    input ready);
    modport sink   (input valid, input mode, input button_levels, input now_ms,
                    output ready);
endinterface

interface bgd_out_if;
    import bgd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] button_index;
    logic [CODE_W-1:0]    event_code;
    logic                 last_event;

    modport source (output valid, output button_index, output event_code,
                    output last_event, input ready);
    modport sink   (input valid, input button_index, input event_code,
                    input last_event, output ready);
endinterface

>>> hw/rtl/bgd_front.sv
// Front end: configuration registers, per-button gesture state and event classification.
module bgd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bgd_in_if.sink                        i_in,
    input  logic                          i_cfg_we,
    input  logic [bgd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bgd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  bgd_pkg::t_evq_stat            i_q_stat,
    output logic                          o_push,
    output bgd_pkg::t_ev_mask             o_push_mask
);
    import bgd_pkg::*;

    logic [THR_W-1:0] r_long_ms;
    logic [THR_W-1:0] r_double_ms;
    logic             r_invert;

    t_gesture          r_state    [NUM_BUTTONS];
    logic              r_prev     [NUM_BUTTONS];
    logic              r_lfired   [NUM_BUTTONS];
    logic              r_awaiting [NUM_BUTTONS];
    logic [TIME_W-1:0] r_press_ms [NUM_BUTTONS];
    logic [TIME_W-1:0] r_rel_ms   [NUM_BUTTONS];

    t_gesture          n_state    [NUM_BUTTONS];
    logic              n_prev     [NUM_BUTTONS];
    logic              n_lfired   [NUM_BUTTONS];
    logic              n_awaiting [NUM_BUTTONS];
    logic [TIME_W-1:0] n_press_ms [NUM_BUTTONS];
    logic [TIME_W-1:0] n_rel_ms   [NUM_BUTTONS];

    logic                       accept;
    logic [NUM_BUTTONS-1:0]     pressed;
    logic [NUM_BUTTONS+LEVEL_W-1:0] lv_pad;
    t_ev_mask                   ev;

    // Items are taken whenever the queue has room.
    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;

    // Buttons beyond the level field read level zero.
    assign lv_pad = {{NUM_BUTTONS{1'b0}}, i_in.button_levels};

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ms   <= LONG_PRESS_RST;
            r_double_ms <= DOUBLE_CLICK_RST;
            r_invert    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LONG_PRESS:   r_long_ms   <= i_cfg_data[THR_W-1:0];
                CFG_DOUBLE_CLICK: r_double_ms <= i_cfg_data[THR_W-1:0];
                CFG_INVERT:       r_invert    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Each button's next state and events; the buttons are independent lanes.
    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            n_state[i]    = r_state[i];
            n_prev[i]     = r_prev[i];
            n_lfired[i]   = r_lfired[i];
            n_awaiting[i] = r_awaiting[i];
            n_press_ms[i] = r_press_ms[i];
            n_rel_ms[i]   = r_rel_ms[i];
            ev[i]         = '0;
            pressed[i]    = lv_pad[i] ^ r_invert;

            if (i_in.mode == MODE_SAMPLE) begin
                if (pressed[i] != r_prev[i]) begin
                    n_prev[i] = pressed[i];
                    if (pressed[i]) begin
                        n_press_ms[i]     = i_in.now_ms;
                        n_lfired[i]       = 1'b0;
                        n_state[i]        = G_PRESSED;
                        ev[i][EVB_PRESS]  = 1'b1;
                    end else begin
                        n_rel_ms[i]        = i_in.now_ms;
                        ev[i][EVB_RELEASE] = 1'b1;
                        if (r_state[i] == G_PRESSED && !r_lfired[i]) begin
                            if (r_awaiting[i]) begin
                                n_awaiting[i]     = 1'b0;
                                n_state[i]        = G_IDLE;
                                ev[i][EVB_DOUBLE] = 1'b1;
                            end else begin
                                n_awaiting[i] = 1'b1;
                                n_state[i]    = G_RELEASED;
                            end
                        end else if (r_state[i] == G_LONG) begin
                            n_state[i] = G_IDLE;
                        end
                    end
                end
            end else begin
                // Timer check: long press while held, click once the window expires.
                if (r_state[i] == G_PRESSED) begin
                    if (r_prev[i] && !r_lfired[i] &&
                        (i_in.now_ms - r_press_ms[i]) >= TIME_W'(r_long_ms)) begin
                        n_lfired[i]     = 1'b1;
                        n_state[i]      = G_LONG;
                        ev[i][EVB_LONG] = 1'b1;
                    end
                end else if (r_state[i] == G_RELEASED) begin
                    if (r_awaiting[i] &&
                        (i_in.now_ms - r_rel_ms[i]) >= TIME_W'(r_double_ms)) begin
                        n_awaiting[i]    = 1'b0;
                        n_state[i]       = G_IDLE;
                        ev[i][EVB_CLICK] = 1'b1;
                    end
                end
            end
        end
    end

    // Gesture control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_state[i]    <= G_IDLE;
                r_prev[i]     <= 1'b0;
                r_lfired[i]   <= 1'b0;
                r_awaiting[i] <= 1'b0;
            end
        end else if (accept) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_state[i]    <= n_state[i];
                r_prev[i]     <= n_prev[i];
                r_lfired[i]   <= n_lfired[i];
                r_awaiting[i] <= n_awaiting[i];
            end
        end
    end

    // Time stamps are only read after a press or release has written them.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_press_ms[i] <= n_press_ms[i];
                r_rel_ms[i]   <= n_rel_ms[i];
            end
        end
    end

    // Only items that cause events go into the queue.
    assign o_push      = accept && (|ev);
    assign o_push_mask = ev;

endmodule

>>> hw/rtl/bgd_evq.sv
// Short FIFO of per-item event masks between the front and back ends.
module bgd_evq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bgd_pkg::t_ev_mask   i_push_mask,
    input  logic                i_pop,
    output bgd_pkg::t_ev_mask   o_head,
    output bgd_pkg::t_evq_stat  o_stat
);
    import bgd_pkg::*;

    t_ev_mask               r_mem [EVQ_DEPTH];
    logic [EVQ_PTR_W-1:0]   r_wr_ptr;
    logic [EVQ_PTR_W-1:0]   r_rd_ptr;
    logic [EVQ_CNT_W-1:0]   r_count;

    // Pointer advance with wrap at the queue depth.
    function automatic logic [EVQ_PTR_W-1:0] ptr_inc(input logic [EVQ_PTR_W-1:0] p);
        return (p == EVQ_PTR_W'(EVQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_mask;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == EVQ_CNT_W'(EVQ_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

>>> hw/rtl/bgd_back.sv
// Back end: serializes each item's event mask into one output transfer per event.
module bgd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bgd_pkg::t_ev_mask   i_q_head,
    input  bgd_pkg::t_evq_stat  i_q_stat,
    output logic                o_pop,
    bgd_out_if.source           o_out
);
    import bgd_pkg::*;

    t_ev_mask               r_work;
    t_ev_mask               n_work;
    t_ev_mask               rem;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_valid;
    logic [OUT_IDX_W-1:0]   r_idx;
    logic [CODE_W-1:0]      r_code;
    logic                   r_last;

    logic                   adv;
    logic                   have;
    logic [BTN_IDX_W-1:0]   sel_btn;
    logic [EVB_W-1:0]       sel_bit;
    t_btn_ev                sel_ev;
    logic                   is_last;

    assign adv  = !r_valid || o_out.ready;
    assign have = |r_work;

    // Lowest button with a pending event, then its lowest pending event bit.
    always_comb begin
        sel_btn = '0;
        for (int b = NUM_BUTTONS - 1; b >= 0; b--) begin
            if (|r_work[b]) begin
                sel_btn = BTN_IDX_W'(b);
            end
        end
        sel_ev  = r_work[sel_btn];
        sel_bit = '0;
        for (int k = EVB_NUM - 1; k >= 0; k--) begin
            if (sel_ev[k]) begin
                sel_bit = EVB_W'(k);
            end
        end
        rem                   = r_work;
        rem[sel_btn][sel_bit] = 1'b0;
    end

    // The last event of an item is the final pending one or the result cap.
    assign is_last = (rem == '0) || (r_cnt == CNT_W'(MAX_RESULTS - 1));

    // Work mask after this cycle, refilled from the queue once drained.
    always_comb begin
        n_work = r_work;
        if (adv && have) begin
            n_work = is_last ? '0 : rem;
        end
        o_pop = (n_work == '0) && !i_q_stat.empty;
        if (o_pop) begin
            n_work = i_q_head;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work  <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_work <= n_work;
            if (adv) begin
                r_valid <= have;
                if (have) begin
                    r_cnt <= is_last ? '0 : r_cnt + 1'b1;
                end
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (adv && have) begin
            r_idx  <= out_idx(sel_btn);
            r_code <= ev_code(sel_bit);
            r_last <= is_last;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.button_index = r_idx;
    assign o_out.event_code   = r_code;
    assign o_out.last_event   = r_last;

endmodule

>>> hw/rtl/button_gesture_detector_core.sv
// Top level of the button gesture detector.
//
// Usage: input items arrive on i_in (mode, button_levels, now_ms); mode 0 is a
// level sample and mode 1 a timer check. Each event leaves on o_out as one
// transfer carrying button_index, event_code and last_event, which marks the
// final event of its item. Items that cause no event produce no transfer.
// Thresholds and level inversion are written through i_cfg_we/i_cfg_idx/
// i_cfg_data while the block is idle.
// The first event of an item passes the event queue, the work mask register
// and the output register before it appears on o_out. Throughput: an item
// is taken every cycle while the four-entry event queue has room; the output
// register then drains one event per cycle while o_out.ready is high.
// Reset (synchronous, active low) restores thresholds of 1000 ms and 300 ms,
// clears inversion, sets every button idle and empties the queue.
// When the receiver stalls, the current event holds on o_out, the queue fills
// and i_in.ready falls only once the queue is full.
module button_gesture_detector_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bgd_in_if.sink                        i_in,
    bgd_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [bgd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bgd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bgd_pkg::*;

    logic       push;
    t_ev_mask   push_mask;
    logic       pop;
    t_ev_mask   q_head;
    t_evq_stat  q_stat;

    // Classification and gesture state.
    bgd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_mask (push_mask)
    );

    // Decoupling queue.
    bgd_evq u_evq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_mask (push_mask),
        .i_pop       (pop),
        .o_head      (q_head),
        .o_stat      (q_stat)
    );

    // Event serialization.
    bgd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_head (q_head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

>>> hw/rtl/bgd_checker.sv
// Port-level assertions for the button gesture detector, bound to the top level.
module bgd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [bgd_pkg::OUT_IDX_W-1:0]  i_out_index,
    input logic [bgd_pkg::CODE_W-1:0]     i_out_code,
    input logic                           i_out_last
);
    import bgd_pkg::*;

    // A stalled event holds its payload until the transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_index) && $stable(i_out_code)
            && $stable(i_out_last))
        else $error("output event changed while stalled");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // Reset empties the queue, so items are taken right away.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    // Only the five defined event codes appear.
    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_code == EV_PRESS) || (i_out_code == EV_RELEASE)
            || (i_out_code == EV_CLICK) || (i_out_code == EV_DOUBLE)
            || (i_out_code == EV_LONG))
        else $error("undefined event code");

endmodule

bind button_gesture_detector_core bgd_checker u_bgd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_index (o_out.button_index),
    .i_out_code  (o_out.event_code),
    .i_out_last  (o_out.last_event)
);
